// File: rtl/piecewise_linear_calibration_table_defines.svh
// assertion macros used by the calibration table checker
`ifndef PIECEWISE_LINEAR_CALIBRATION_TABLE_DEFINES_SVH
`define PIECEWISE_LINEAR_CALIBRATION_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PLCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calibration table check failed");

// next-cycle implication, sampled on clk, off during reset
`define PLCT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calibration table check failed");

`endif

// File: rtl/plct_pkg.sv
// types, constants and control structs of the calibration table
package plct_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = (ADDR_W + 1 > 7) ? ADDR_W + 1 : 7;
    localparam int PC_W       = 7;
    localparam int DATA_W     = 32;
    // sums of positions / corrections, and of their products
    localparam int SUM_W      = DATA_W + ADDR_W + 1;
    localparam int ACC_W      = 66 + 2 * ADDR_W;
    // divider: dividend bits and divisor bits
    localparam int NUM_W      = ACC_W + 16;
    localparam int DEN_W      = ACC_W;

    localparam logic [1:0] CMD_LOAD      = 2'd0;
    localparam logic [1:0] CMD_EVAL      = 2'd1;
    localparam logic [1:0] CMD_ADD_SLOPE = 2'd2;
    localparam logic [1:0] CMD_LSQ_SLOPE = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FEW  = 2'd1;
    localparam logic [1:0] STAT_SPAN = 2'd2;

    localparam int REG_POINT_COUNT = 0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EV_SCAN,
        ST_EV_LO,
        ST_EV_DIFF,
        ST_EV_MUL,
        ST_EV_DIVLD,
        ST_DIV,
        ST_FIN,
        ST_AS_RD,
        ST_AS_WR,
        ST_LS_RD,
        ST_LS_SQ,
        ST_LS_ACC,
        ST_LS_NMUL,
        ST_LS_SER,
        ST_LS_CHK
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_EVAL,
        RES_SLOPE,
        RES_LOWER
    } res_src_t;

    typedef struct packed {
        logic              cap_in;
        logic              load_wr;
        logic              cap_hi;
        logic              cap_lo;
        logic              diff;
        logic              mul_ev;
        logic              as_mul;
        logic              as_wr;
        logic              ls_clr;
        logic              ls_pc;
        logic              ls_pp;
        logic              ls_acc;
        logic              ls_nmul;
        logic              ser_step;
        logic              ser_last;
        logic              div_ld_ev;
        logic              div_ld_ls;
        logic              div_step;
        logic              done;
        logic [1:0]        status;
        res_src_t          res_src;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic [CNT_W-1:0]  count;
    } ctrl_cmd_t;

    typedef struct packed {
        logic x_below;
        logic span_zero;
        logic den_bad;
    } dp_stat_t;

endpackage

// File: rtl/plct_ram.sv
// generic single-port-write ram with registered read
module plct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/plct_ctrl.sv
// sequencer for load, evaluate, add-slope and least-squares commands
module plct_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            cmd,
    input  logic [6:0]            point_count,
    input  plct_pkg::dp_stat_t    st,
    output plct_pkg::ctrl_cmd_t   ctl,
    output logic                  busy
);
    import plct_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [1:0]       op_reg, op_next;
    logic [CNT_W-1:0] n;
    logic             last_pt;

    // points in use, clamped to the table size
    assign n = (CNT_W'(point_count) > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                          : CNT_W'(point_count);
    assign last_pt = (idx_reg == n - CNT_W'(1));
    assign busy    = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            op_reg    <= CMD_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        ctl         = '0;
        ctl.count   = n;
        ctl.status  = STAT_OK;
        ctl.res_src = RES_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.cap_in = 1'b1;
                    op_next    = cmd;
                    case (cmd)
                        CMD_LOAD:
                        begin
                            ctl.load_wr = 1'b1;
                            ctl.done    = 1'b1;
                        end
                        CMD_EVAL:
                        begin
                            if (n < CNT_W'(2))
                            begin
                                ctl.done   = 1'b1;
                                ctl.status = STAT_FEW;
                            end
                            else
                            begin
                                idx_next   = CNT_W'(1);
                                state_next = ST_EV_SCAN;
                            end
                        end
                        CMD_ADD_SLOPE:
                        begin
                            if (n == '0)
                            begin
                                ctl.done = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_AS_RD;
                            end
                        end
                        CMD_LSQ_SLOPE:
                        begin
                            if (n < CNT_W'(2))
                            begin
                                ctl.done   = 1'b1;
                                ctl.status = STAT_FEW;
                            end
                            else
                            begin
                                ctl.ls_clr = 1'b1;
                                idx_next   = '0;
                                state_next = ST_LS_RD;
                            end
                        end
                    endcase
                end
            end
            ST_EV_SCAN:
            begin
                // first segment whose upper position is above x, else the last
                if (st.x_below || last_pt)
                begin
                    ctl.cap_hi = 1'b1;
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = ST_EV_LO;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_EV_LO:
            begin
                ctl.cap_lo = 1'b1;
                state_next = ST_EV_DIFF;
            end
            ST_EV_DIFF:
            begin
                ctl.diff   = 1'b1;
                state_next = ST_EV_MUL;
            end
            ST_EV_MUL:
            begin
                if (st.span_zero)
                begin
                    ctl.done    = 1'b1;
                    ctl.status  = STAT_SPAN;
                    ctl.res_src = RES_LOWER;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ctl.mul_ev = 1'b1;
                    state_next = ST_EV_DIVLD;
                end
            end
            ST_EV_DIVLD:
            begin
                ctl.div_ld_ev = 1'b1;
                idx_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                if (idx_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                ctl.done    = 1'b1;
                ctl.res_src = (op_reg == CMD_EVAL) ? RES_EVAL : RES_SLOPE;
                state_next  = ST_IDLE;
            end
            ST_AS_RD:
            begin
                ctl.as_mul = 1'b1;
                state_next = ST_AS_WR;
            end
            ST_AS_WR:
            begin
                ctl.as_wr = 1'b1;
                if (last_pt)
                begin
                    ctl.done   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_AS_RD;
                end
            end
            ST_LS_RD:
            begin
                ctl.ls_pc  = 1'b1;
                state_next = ST_LS_SQ;
            end
            ST_LS_SQ:
            begin
                ctl.ls_pp  = 1'b1;
                state_next = ST_LS_ACC;
            end
            ST_LS_ACC:
            begin
                ctl.ls_acc = 1'b1;
                if (last_pt)
                begin
                    state_next = ST_LS_NMUL;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_LS_RD;
                end
            end
            ST_LS_NMUL:
            begin
                ctl.ls_nmul = 1'b1;
                idx_next    = '0;
                state_next  = ST_LS_SER;
            end
            ST_LS_SER:
            begin
                ctl.ser_step = 1'b1;
                if (idx_reg == CNT_W'(SUM_W - 1))
                begin
                    ctl.ser_last = 1'b1;
                    state_next   = ST_LS_CHK;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_LS_CHK:
            begin
                if (st.den_bad)
                begin
                    ctl.done   = 1'b1;
                    ctl.status = STAT_SPAN;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.div_ld_ls = 1'b1;
                    idx_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // ram data always belongs to the current index
        ctl.rd_addr = idx_next[ADDR_W-1:0];
        ctl.wr_addr = idx_reg[ADDR_W-1:0];
    end

endmodule

// File: rtl/plct_dp.sv
// datapath: breakpoint rams, multiplier, accumulators, divider, result register
module plct_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  plct_pkg::ctrl_cmd_t         ctl,
    output plct_pkg::dp_stat_t          st,
    input  logic [5:0]                  index,
    input  logic signed [31:0]          position,
    input  logic signed [31:0]          correction,
    input  logic signed [31:0]          slope,
    output logic                        done,
    output logic signed [31:0]          result,
    output logic [1:0]                  status
);
    import plct_pkg::*;

    localparam int SAT_W = 52;

    function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [31:0] r;
        if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31]))
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[SAT_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return r;
    endfunction

    logic signed [31:0]      pos_rd, cor_rd;
    logic signed [31:0]      x_reg, slp_reg, p_hi_reg, c_hi_reg, p_lo_reg, c_lo_reg;
    logic signed [32:0]      span_reg, dx_reg, dy_reg;
    logic signed [65:0]      prod_reg;
    logic signed [32:0]      mul_a, mul_b;
    logic signed [65:0]      mul_p;
    logic signed [SUM_W-1:0] sxs_reg, sys_reg, bsy_reg, bsx_reg;
    logic signed [ACC_W-1:0] sxy_reg, sxx_reg, num_reg, den_reg, ash_reg;
    logic signed [ACC_W-1:0] nsxy, nsxx;
    logic [DEN_W-1:0]        rem_reg, dsr_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic                    neg_reg;
    logic                    done_reg;
    logic [31:0]             result_reg;
    logic [1:0]              status_reg;

    logic                    ld_ok;
    logic                    cor_we;
    logic [ADDR_W-1:0]       cor_waddr;
    logic [31:0]             cor_wdata;
    logic [65:0]             prod_mag;
    logic [32:0]             span_mag;
    logic [ACC_W-1:0]        num_mag;
    logic signed [SAT_W-1:0] as_t, as_sum;
    logic [31:0]             as_res;
    logic [DEN_W:0]          r_sh;
    logic [DEN_W+1:0]        r_diff;
    logic                    q_bit;
    logic [34:0]             ev_qc;
    logic signed [SAT_W-1:0] ev_q, ev_sum;
    logic [31:0]             sl_res;
    logic [31:0]             res_sel;

    assign ld_ok     = ctl.load_wr && (32'(index) < MAX_POINTS);
    assign cor_we    = ld_ok || ctl.as_wr;
    assign cor_waddr = ctl.load_wr ? ADDR_W'(index) : ctl.wr_addr;
    assign cor_wdata = ctl.load_wr ? correction : as_res;

    plct_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_pos_ram (
        .clk   (clk),
        .we    (ld_ok),
        .waddr (ADDR_W'(index)),
        .wdata (position),
        .raddr (ctl.rd_addr),
        .rdata (pos_rd)
    );

    plct_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_cor_ram (
        .clk   (clk),
        .we    (cor_we),
        .waddr (cor_waddr),
        .wdata (cor_wdata),
        .raddr (ctl.rd_addr),
        .rdata (cor_rd)
    );

    assign st.x_below   = (x_reg < pos_rd);
    assign st.span_zero = (span_reg == '0);
    assign st.den_bad   = den_reg[ACC_W-1] || (den_reg == '0);

    // shared signed multiplier for the evaluate, add-slope and per-point products
    always_comb
    begin
        if (ctl.mul_ev)
        begin
            mul_a = dx_reg;
            mul_b = dy_reg;
        end
        else if (ctl.as_mul)
        begin
            mul_a = 33'(slp_reg);
            mul_b = 33'(pos_rd);
        end
        else if (ctl.ls_pc)
        begin
            mul_a = 33'(pos_rd);
            mul_b = 33'(cor_rd);
        end
        else
        begin
            mul_a = 33'(p_lo_reg);
            mul_b = 33'(p_lo_reg);
        end
    end
    assign mul_p = mul_a * mul_b;

    assign prod_mag = prod_reg[65] ? 66'(-prod_reg) : 66'(prod_reg);
    assign span_mag = span_reg[32] ? 33'(-span_reg) : 33'(span_reg);
    assign num_mag  = num_reg[ACC_W-1] ? ACC_W'(-num_reg) : ACC_W'(num_reg);

    // add slope: truncate the Q50.16 product toward zero, then saturate
    assign as_t   = prod_reg[65] ? -$signed(SAT_W'(prod_mag[65:16]))
                                 : $signed(SAT_W'(prod_mag[65:16]));
    assign as_sum = SAT_W'(c_lo_reg) + as_t;
    assign as_res = sat32(as_sum);

    assign nsxy = sxy_reg * $signed({1'b0, ctl.count});
    assign nsxx = sxx_reg * $signed({1'b0, ctl.count});

    // restoring divider, one quotient bit per cycle
    assign r_sh   = {rem_reg, quo_reg[NUM_W-1]};
    assign r_diff = {1'b0, r_sh} - {2'b00, dsr_reg};
    assign q_bit  = !r_diff[DEN_W+1];

    // clamp the quotient, any larger value saturates the sum anyway
    assign ev_qc  = (|quo_reg[NUM_W-1:34]) ? (35'd1 << 34) : quo_reg[34:0];
    assign ev_q   = neg_reg ? -$signed(SAT_W'(ev_qc)) : $signed(SAT_W'(ev_qc));
    assign ev_sum = SAT_W'(c_lo_reg) + ev_q;

    always_comb
    begin
        if (|quo_reg[NUM_W-1:31])
        begin
            sl_res = neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        else
        begin
            sl_res = neg_reg ? (32'd0 - quo_reg[31:0]) : quo_reg[31:0];
        end
    end

    always_comb
    begin
        case (ctl.res_src)
            RES_EVAL:  res_sel = sat32(ev_sum);
            RES_SLOPE: res_sel = sl_res;
            RES_LOWER: res_sel = c_lo_reg;
            default:   res_sel = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_in)
        begin
            x_reg   <= position;
            slp_reg <= slope;
        end
        if (ctl.cap_hi)
        begin
            p_hi_reg <= pos_rd;
            c_hi_reg <= cor_rd;
        end
        if (ctl.cap_lo || ctl.ls_pc)
        begin
            p_lo_reg <= pos_rd;
        end
        if (ctl.cap_lo || ctl.as_mul)
        begin
            c_lo_reg <= cor_rd;
        end
        if (ctl.diff)
        begin
            span_reg <= 33'(p_hi_reg) - 33'(p_lo_reg);
            dx_reg   <= 33'(x_reg) - 33'(p_lo_reg);
            dy_reg   <= 33'(c_hi_reg) - 33'(c_lo_reg);
        end
        if (ctl.mul_ev || ctl.as_mul || ctl.ls_pc || ctl.ls_pp)
        begin
            prod_reg <= mul_p;
        end
        if (ctl.ls_clr)
        begin
            sxs_reg <= '0;
            sys_reg <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
        end
        if (ctl.ls_pc)
        begin
            sxs_reg <= sxs_reg + SUM_W'(pos_rd);
            sys_reg <= sys_reg + SUM_W'(cor_rd);
        end
        if (ctl.ls_pp)
        begin
            sxy_reg <= sxy_reg + ACC_W'(prod_reg);
        end
        if (ctl.ls_acc)
        begin
            sxx_reg <= sxx_reg + ACC_W'(prod_reg);
        end
        if (ctl.ls_nmul)
        begin
            num_reg <= nsxy;
            den_reg <= nsxx;
            ash_reg <= ACC_W'(sxs_reg);
            bsy_reg <= sys_reg;
            bsx_reg <= sxs_reg;
        end
        // bit-serial subtract of sx*sy and sx*sx; the top bit weighs negative
        if (ctl.ser_step)
        begin
            if (bsy_reg[0])
            begin
                num_reg <= ctl.ser_last ? num_reg + ash_reg : num_reg - ash_reg;
            end
            if (bsx_reg[0])
            begin
                den_reg <= ctl.ser_last ? den_reg + ash_reg : den_reg - ash_reg;
            end
            ash_reg <= ash_reg <<< 1;
            bsy_reg <= bsy_reg >>> 1;
            bsx_reg <= bsx_reg >>> 1;
        end
        if (ctl.div_ld_ev)
        begin
            quo_reg <= NUM_W'(prod_mag);
            rem_reg <= '0;
            dsr_reg <= DEN_W'(span_mag);
            neg_reg <= prod_reg[65] ^ span_reg[32];
        end
        if (ctl.div_ld_ls)
        begin
            quo_reg <= NUM_W'(num_mag) << 16;
            rem_reg <= '0;
            dsr_reg <= den_reg;
            neg_reg <= num_reg[ACC_W-1];
        end
        if (ctl.div_step)
        begin
            rem_reg <= q_bit ? r_diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
        end
        if (ctl.done)
        begin
            result_reg <= res_sel;
            status_reg <= ctl.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.done;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign status = status_reg;

endmodule

// File: rtl/piecewise_linear_calibration_table.sv
// top level: apb register, sequencer and datapath of the calibration table
// Accepts a command when start is high and busy is low; each command gives one
// result, shown on result/status for one cycle with done high, which must be
// taken in that cycle. A load completes without going busy. Evaluate finds its
// segment s by a linear scan, one entry per cycle (s is 1 to 63). Add slope
// does one multiply and one write-back per point. The least-squares slope
// accumulates each point on the shared multiplier, forms the bit-serial cross
// products, then runs the restoring divider, which evaluate uses as well.
// Evaluate and least-squares with fewer than two points, and add slope with no
// points, finish without going busy. Breakpoint entries hold no reset value;
// read only entries that were loaded.
module piecewise_linear_calibration_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [5:0]         index,
    input  logic signed [31:0] position,
    input  logic signed [31:0] correction,
    input  logic signed [31:0] slope,
    output logic               done,
    output logic signed [31:0] result,
    output logic [1:0]         status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import plct_pkg::*;

    logic [PC_W-1:0] point_count_reg;
    ctrl_cmd_t       ctl;
    dp_stat_t        st;
    logic            reg_sel;

    assign reg_sel = (32'(paddr[2]) == REG_POINT_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? 32'(point_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            point_count_reg <= pwdata[PC_W-1:0];
        end
    end

    plct_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .point_count (point_count_reg),
        .st          (st),
        .ctl         (ctl),
        .busy        (busy)
    );

    plct_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .st         (st),
        .index      (index),
        .position   (position),
        .correction (correction),
        .slope      (slope),
        .done       (done),
        .result     (result),
        .status     (status)
    );

endmodule

// File: rtl/plct_checker.sv
// port-level checks of the calibration table command handshake
`include "piecewise_linear_calibration_table_defines.svh"

module plct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] cmd,
    input logic       done
);
    import plct_pkg::*;

    // a result only shows once the block has gone idle
    `PLCT_ASSERT_IMP(a_done_idle, done, !busy)
    // finishing a long command always gives a result
    `PLCT_ASSERT_IMP(a_fall_done, $fell(busy), done)
    // busy only rises after a command transfer
    `PLCT_ASSERT_IMP(a_rise_start, $rose(busy), $past(start))
    // a load answers in the next cycle without going busy
    `PLCT_ASSERT_NXT(a_load_quick, start && !busy && cmd == CMD_LOAD, done && !busy)

endmodule

bind piecewise_linear_calibration_table plct_checker u_plct_checker (.*);
